FILE: rtl/core/rgbhsl_pkg.sv
package rgbhsl_pkg;

    localparam int OutW    = 13;
    localparam int QuoW    = 13;   // quotient bits developed by the divider chain
    localparam int DivW    = 9;    // divisor width (d or den, at most 255)
    localparam int RemW    = 10;   // partial remainder width
    localparam int NumW    = 23;   // dividend width (num up to 5760*255)

    localparam logic [12:0] HueSixth = 13'd960;

    // Payload carried along the divider chain.
    typedef struct packed {
        logic            valid;
        logic [NumW-1:0] hue_num;   // hue dividend, shifted left one bit per cell
        logic [RemW-1:0] hue_rem;
        logic [DivW-1:0] hue_div;
        logic [NumW-1:0] sat_num;
        logic [RemW-1:0] sat_rem;
        logic [DivW-1:0] sat_div;
        logic [QuoW-1:0] hue_quo;
        logic [QuoW-1:0] sat_quo;
        logic            zero;      // grey pixel or zero denominator
        logic [OutW-1:0] light;
    } div_bus_t;

endpackage

FILE: rtl/core/rgbhsl_cell.sv
// One restoring-division step for both hue and saturation quotients.
module rgbhsl_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rgbhsl_pkg::div_bus_t  din,
    output rgbhsl_pkg::div_bus_t  dout
);

    rgbhsl_pkg::div_bus_t step_next;
    rgbhsl_pkg::div_bus_t step_reg;
    logic [rgbhsl_pkg::RemW:0] hue_try;
    logic [rgbhsl_pkg::RemW:0] sat_try;

    always_comb
    begin
        step_next = din;
        hue_try = {din.hue_rem, din.hue_num[rgbhsl_pkg::NumW-1]}
                  - {2'b00, din.hue_div};
        sat_try = {din.sat_rem, din.sat_num[rgbhsl_pkg::NumW-1]}
                  - {2'b00, din.sat_div};
        step_next.hue_num = {din.hue_num[rgbhsl_pkg::NumW-2:0], 1'b0};
        step_next.sat_num = {din.sat_num[rgbhsl_pkg::NumW-2:0], 1'b0};
        if (hue_try[rgbhsl_pkg::RemW])
        begin
            step_next.hue_rem = {din.hue_rem[rgbhsl_pkg::RemW-2:0],
                                 din.hue_num[rgbhsl_pkg::NumW-1]};
            step_next.hue_quo = {din.hue_quo[rgbhsl_pkg::QuoW-2:0], 1'b0};
        end
        else
        begin
            step_next.hue_rem = hue_try[rgbhsl_pkg::RemW-1:0];
            step_next.hue_quo = {din.hue_quo[rgbhsl_pkg::QuoW-2:0], 1'b1};
        end
        if (sat_try[rgbhsl_pkg::RemW])
        begin
            step_next.sat_rem = {din.sat_rem[rgbhsl_pkg::RemW-2:0],
                                 din.sat_num[rgbhsl_pkg::NumW-1]};
            step_next.sat_quo = {din.sat_quo[rgbhsl_pkg::QuoW-2:0], 1'b0};
        end
        else
        begin
            step_next.sat_rem = sat_try[rgbhsl_pkg::RemW-1:0];
            step_next.sat_quo = {din.sat_quo[rgbhsl_pkg::QuoW-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else
            step_reg <= step_next;
    end

    assign dout = step_reg;

endmodule

FILE: rtl/core/rgbhsl_front.sv
// Max/min, lightness and dividend setup; registered.
module rgbhsl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    output rgbhsl_pkg::div_bus_t  dout
);

    rgbhsl_pkg::div_bus_t front_next;
    rgbhsl_pkg::div_bus_t front_reg;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [8:0]  sum;
    logic [8:0]  den;
    logic [12:0] light_y;
    logic [21:0] light_prod;
    logic [22:0] base;
    logic [22:0] term;
    logic [22:0] num;
    logic        neg;
    logic [7:0]  diff;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        den = (sum <= 9'd255) ? sum : 9'(10'd510 - {1'b0, sum});
        // floor(4096*sum/510) = 8*sum + floor(8*sum/255);
        // floor(y/255) = ((y+1)*257) >> 16, exact for y up to 4080
        light_y    = {1'b0, sum, 3'b000} + 13'd1;
        light_prod = {1'b0, light_y, 8'b0} + {9'b0, light_y};
        neg  = 1'b0;
        diff = 8'd0;
        base = 23'd0;
        if (mx == red)
        begin
            neg  = green < blue;
            diff = neg ? blue - green : green - blue;
            base = neg ? 23'd5760 * 23'(d) : 23'd0;
        end
        else if (mx == green)
        begin
            neg  = blue < red;
            diff = neg ? red - blue : blue - red;
            base = 23'd1920 * 23'(d);
        end
        else
        begin
            neg  = red < green;
            diff = neg ? green - red : red - green;
            base = 23'd3840 * 23'(d);
        end
        term = 23'(rgbhsl_pkg::HueSixth) * 23'(diff);
        num  = neg ? base - term : base + term;

        front_next.valid   = load;
        front_next.hue_num = num;
        front_next.hue_rem = '0;
        front_next.hue_div = {1'b0, d};
        front_next.sat_num = {2'b00, d, 13'b0} >> 1;   // 4096*d placed at quotient scale
        front_next.sat_rem = '0;
        front_next.sat_div = den;
        front_next.hue_quo = '0;
        front_next.sat_quo = '0;
        front_next.zero    = (d == 8'd0);
        front_next.light   = {1'b0, sum, 3'b000} + {7'b0, light_prod[21:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_reg <= '0;
        else
        begin
            front_reg.valid   <= front_next.valid;
            front_reg.hue_num <= front_next.hue_num << 10;
            front_reg.hue_rem <= front_next.hue_num[22:13];
            front_reg.hue_div <= front_next.hue_div;
            front_reg.sat_num <= {front_next.sat_num[12:0], 10'b0};
            front_reg.sat_rem <= front_next.sat_num[22:13];
            front_reg.sat_div <= front_next.sat_div;
            front_reg.hue_quo <= '0;
            front_reg.sat_quo <= '0;
            front_reg.zero    <= front_next.zero;
            front_reg.light   <= front_next.light;
        end
    end

    assign dout = front_reg;

endmodule

FILE: rtl/core/rgb_to_hsl_convert_top.sv
// Channel   Signals                          Direction
// command   start, busy, red, green, blue     in (busy out)
// result    done, hue, saturation, lightness  out, one-cycle strobe
//
// One transaction per clock; the pipeline is a setup stage plus 13
// divider cells, one quotient bit per cell for hue and saturation.
// The cell chain sets the latency; throughput is one pixel per clock.
// busy is always low: the receiver cannot stall and nothing backs up.
// rst_n clears every stage register asynchronously.
module rgb_to_hsl_convert_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        done,
    output logic [12:0] hue,
    output logic [12:0] saturation,
    output logic [12:0] lightness
);

    rgbhsl_pkg::div_bus_t chain [rgbhsl_pkg::QuoW+1];

    assign busy = 1'b0;

    // Dividend top 10 bits preloaded as remainder; numerators fit (hue < 2^23,
    // and remainder stays below divisor since quotient fits 13 bits).
    rgbhsl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (start && !busy),
        .red   (red),
        .green (green),
        .blue  (blue),
        .dout  (chain[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < rgbhsl_pkg::QuoW; gi++)
        begin : g_cell
            rgbhsl_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .din   (chain[gi]),
                .dout  (chain[gi+1])
            );
        end
    endgenerate

    assign done       = chain[rgbhsl_pkg::QuoW].valid;
    assign hue        = chain[rgbhsl_pkg::QuoW].zero ? '0 : chain[rgbhsl_pkg::QuoW].hue_quo;
    assign saturation = chain[rgbhsl_pkg::QuoW].zero ? '0 : chain[rgbhsl_pkg::QuoW].sat_quo;
    assign lightness  = chain[rgbhsl_pkg::QuoW].light;

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue < 13'd5760) else $error("hue out of range");
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> saturation <= 13'd4096) else $error("saturation out of range");
    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> lightness <= 13'd4096) else $error("lightness out of range");

endmodule
